FILE: design/rfcs_pkg.sv
// Shared types and constants for the register file with context stack.
package rfcs_pkg;

    // Operation codes carried in the input transaction.
    localparam logic [2:0] OP_READ_GPR   = 3'd0;
    localparam logic [2:0] OP_WRITE_GPR  = 3'd1;
    localparam logic [2:0] OP_READ_CORE  = 3'd2;
    localparam logic [2:0] OP_WRITE_CORE = 3'd3;
    localparam logic [2:0] OP_SAVE       = 3'd4;
    localparam logic [2:0] OP_RESTORE    = 3'd5;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    // Words in one saved upper-context frame, and the general index of the pc.
    localparam int unsigned FRAME_WORDS = 15;
    localparam logic [5:0]  GPR_PC_IDX  = 6'd32;

    // Addresses of the four core special registers, by slot.
    localparam int unsigned   CORE_REGS = 4;
    localparam logic [15:0] CORE_ADDR [CORE_REGS] = '{16'hfe08, 16'hfe00, 16'hfe3c, 16'hfe38};

    // Input transaction payload.
    typedef struct packed {
        logic [2:0]  operation;
        logic [15:0] register_id;
        logic [31:0] write_value;
        logic [3:0]  instr_bytes;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // an input transaction is accepted this cycle
        logic save_step;  // write one frame word to the stack
        logic load_step;  // read one frame word back from the stack
        logic finish;     // the save or restore completes this cycle
        logic load_out;   // capture a result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_save;  // offered transaction is a save that fits on the stack
        logic go_load;  // offered transaction is a restore with a frame to pop
        logic last;     // the current step is the final one of its sequence
    } t_dp_sts;

endpackage

FILE: design/register_file_with_context_stack_unit.sv
// Top level of the register file with upper-context save and restore stack.
//
// Each input transaction gives exactly one result transaction. Register reads
// and writes, and saves or restores that are refused for a full or empty
// stack, finish on acceptance. A save or restore that goes ahead moves each of
// the 15 frame words through the single port of the stack memory one word at a
// time, and a restore also waits for the registered read data. A result waits
// in an output register; a new transaction is taken once the controller is idle
// and that register is free or is being emptied. The stack memory holds
// 15 * STACK_DEPTH words and needs no clearing after reset.
module register_file_with_context_stack_unit
    import rfcs_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencing of transactions and stack transfers.
    rfcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Registers, stack and result.
    rfcs_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_item  (i_in_item),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_item (o_out_item)
    );

endmodule

FILE: design/rfcs_ram.sv
// Generic single-port RAM with registered read data.
module rfcs_ram
    import rfcs_pkg::*;
#(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 240
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write or one read per cycle; read data appears on the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end else if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/rfcs_ctrl.sv
// Controller state machine: sequences transactions, save and restore steps.
module rfcs_ctrl
    import rfcs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SAVE = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;

    // A new transaction enters only when idle and the output register is free
    // or is being emptied in the same cycle.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    // Commands to the datapath.
    always_comb begin
        o_cmd           = '0;
        o_cmd.start     = accept;
        o_cmd.save_step = (r_state == S_SAVE);
        o_cmd.load_step = (r_state == S_LOAD);
        o_cmd.finish    = ((r_state == S_SAVE) || (r_state == S_LOAD)) && i_sts.last;
        o_cmd.load_out  = (accept && !i_sts.go_save && !i_sts.go_load) || o_cmd.finish;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sts.go_save) begin
                    n_state = S_SAVE;
                end else if (accept && i_sts.go_load) begin
                    n_state = S_LOAD;
                end
            end
            S_SAVE, S_LOAD: begin
                if (i_sts.last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid flag: set when a result is captured, cleared when taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: design/rfcs_dp.sv
// Datapath: register file, stack pointer, context stack memory and result register.
module rfcs_dp
    import rfcs_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_item o_out_item
);

    localparam int unsigned MEM_DEPTH = FRAME_WORDS * STACK_DEPTH;
    localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
    localparam int unsigned LVL_W     = $clog2(STACK_DEPTH + 1);

    // Frame word position to general register index: a10-a15, d8-d15, pc.
    function automatic logic [5:0] frame_gpr(input logic [3:0] k);
        logic [5:0] idx;
        if (k < 4'd6) begin
            idx = 6'(k) + 6'd10;
        end else if (k < 4'd14) begin
            idx = 6'(k) + 6'd18;
        end else begin
            idx = GPR_PC_IDX;
        end
        return idx;
    endfunction

    logic [31:0]       r_areg [16];
    logic [31:0]       r_dreg [16];
    logic [31:0]       r_pc;
    logic [31:0]       r_core [CORE_REGS];
    logic [LVL_W-1:0]  r_level;
    logic [ADDR_W-1:0] r_base;
    logic [3:0]        r_cnt;
    logic [3:0]        r_isz;
    t_out_item         r_out;

    logic [2:0]        op;
    logic [15:0]       id;
    logic              gpr_ok;
    logic              core_hit;
    logic [1:0]        core_slot;
    logic              stack_full;
    logic              stack_empty;
    logic [5:0]        gpr_ridx;
    logic [31:0]       gpr_rdata;
    logic              gpr_we;
    logic [5:0]        gpr_widx;
    logic [31:0]       gpr_wdata;
    logic              core_we;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_addr;
    logic [31:0]       ram_wdata;
    logic [31:0]       ram_rdata;
    t_out_item         simple_res;

    assign op = i_in_item.operation;
    assign id = i_in_item.register_id;

    // General index decode: 0-15 address, 16-31 data, 32 program counter.
    assign gpr_ok = (id[15:6] == '0) && (!id[5] || (id[4:0] == '0));

    // Core register address match.
    always_comb begin
        core_hit  = 1'b0;
        core_slot = '0;
        for (int i = 0; i < CORE_REGS; i++) begin
            if (id == CORE_ADDR[i]) begin
                core_hit  = 1'b1;
                core_slot = 2'(i);
            end
        end
    end

    assign stack_full  = (r_level >= LVL_W'(STACK_DEPTH));
    assign stack_empty = (r_level == '0);

    // Single general register read port, shared by reads and context saves.
    assign gpr_ridx = i_cmd.save_step ? frame_gpr(r_cnt) : id[5:0];

    always_comb begin
        if (gpr_ridx[5]) begin
            gpr_rdata = r_pc;
        end else if (gpr_ridx[4]) begin
            gpr_rdata = r_dreg[gpr_ridx[3:0]];
        end else begin
            gpr_rdata = r_areg[gpr_ridx[3:0]];
        end
    end

    // Single general register write port, shared by writes and restores.
    always_comb begin
        gpr_we    = 1'b0;
        gpr_widx  = id[5:0];
        gpr_wdata = i_in_item.write_value;
        if (i_cmd.load_step && (r_cnt != 4'd0)) begin
            gpr_we    = 1'b1;
            gpr_widx  = frame_gpr(4'(r_cnt - 4'd1));
            gpr_wdata = ram_rdata;
        end else if (i_cmd.start && (op == OP_WRITE_GPR) && gpr_ok) begin
            gpr_we = 1'b1;
        end
    end

    assign core_we = i_cmd.start && (op == OP_WRITE_CORE) && core_hit;

    // Result of a transaction that completes on acceptance.
    always_comb begin
        simple_res = '0;
        unique case (op)
            OP_READ_GPR: begin
                if (gpr_ok) begin
                    simple_res.read_value = gpr_rdata;
                end else begin
                    simple_res.status = ST_UNKNOWN;
                end
            end
            OP_WRITE_GPR: begin
                simple_res.status = gpr_ok ? ST_OK : ST_UNKNOWN;
            end
            OP_READ_CORE: begin
                if (core_hit) begin
                    simple_res.read_value = r_core[core_slot];
                end else begin
                    simple_res.status = ST_UNKNOWN;
                end
            end
            OP_WRITE_CORE: begin
                simple_res.status = core_hit ? ST_OK : ST_UNKNOWN;
            end
            OP_SAVE: begin
                simple_res.status = stack_full ? ST_OVERFLOW : ST_OK;
            end
            OP_RESTORE: begin
                simple_res.status = stack_empty ? ST_UNDERFLOW : ST_OK;
            end
            default: begin
                simple_res.status = ST_UNKNOWN;
            end
        endcase
    end

    // Status towards the controller.
    always_comb begin
        o_sts         = '0;
        o_sts.go_save = (op == OP_SAVE) && !stack_full;
        o_sts.go_load = (op == OP_RESTORE) && !stack_empty;
        o_sts.last    = (i_cmd.save_step && (r_cnt == 4'(FRAME_WORDS - 1)))
                     || (i_cmd.load_step && (r_cnt == 4'(FRAME_WORDS)));
    end

    // Stack memory access: one frame word per cycle at base plus step.
    assign ram_we    = i_cmd.save_step;
    assign ram_re    = i_cmd.load_step && (r_cnt != 4'(FRAME_WORDS));
    assign ram_addr  = r_base + ADDR_W'(r_cnt);
    assign ram_wdata = (r_cnt == 4'(FRAME_WORDS - 1)) ? (r_pc + 32'(r_isz)) : gpr_rdata;

    rfcs_ram #(
        .WIDTH (32),
        .DEPTH (MEM_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Architectural registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_areg[i] <= '0;
                r_dreg[i] <= '0;
            end
            for (int i = 0; i < CORE_REGS; i++) begin
                r_core[i] <= '0;
            end
            r_pc <= '0;
        end else begin
            if (gpr_we) begin
                if (gpr_widx[5]) begin
                    r_pc <= gpr_wdata;
                end else if (gpr_widx[4]) begin
                    r_dreg[gpr_widx[3:0]] <= gpr_wdata;
                end else begin
                    r_areg[gpr_widx[3:0]] <= gpr_wdata;
                end
            end
            if (core_we) begin
                r_core[core_slot] <= i_in_item.write_value;
            end
        end
    end

    // Stack level and frame base: a pop moves down at its start, a push
    // moves up once its frame is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_base  <= '0;
        end else if (i_cmd.start && o_sts.go_load) begin
            r_level <= r_level - LVL_W'(1);
            r_base  <= r_base - ADDR_W'(FRAME_WORDS);
        end else if (i_cmd.finish && i_cmd.save_step) begin
            r_level <= r_level + LVL_W'(1);
            r_base  <= r_base + ADDR_W'(FRAME_WORDS);
        end
    end

    // Step counter and latched instruction size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.start) begin
            r_cnt <= '0;
        end else if (i_cmd.save_step || i_cmd.load_step) begin
            r_cnt <= r_cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_isz <= i_in_item.instr_bytes;
        end
    end

    // Output register: simple results, or success for a save or restore.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.finish) begin
                r_out.read_value <= '0;
                r_out.status     <= ST_OK;
            end else begin
                r_out <= simple_res;
            end
        end
    end

    assign o_out_item = r_out;

endmodule

FILE: tb/register_file_with_context_stack_unit_tb.sv
// Self-checking testbench for the register file with upper-context stack.
`timescale 1ns / 1ps

module register_file_with_context_stack_unit_tb;
    import rfcs_pkg::*;

    localparam int unsigned STACK_DEPTH   = 16;
    localparam int unsigned REG_COUNT     = 16;
    localparam int unsigned UPPER_A_FIRST = 10;
    localparam int unsigned UPPER_A_COUNT = 6;
    localparam int unsigned UPPER_D_FIRST = 8;
    localparam int unsigned UPPER_D_COUNT = 8;
    localparam int unsigned GAP_MAX       = 18;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned RANDOM_ITEMS  = 600;
    localparam int unsigned NESTED_ITEMS  = 600;

    // Operation codes that the block does not define.
    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    // When set, neither side inserts idle cycles.
    logic steady_flow = 1'b0;

    int unsigned error_count = 0;
    int unsigned items_sent  = 0;

    // Predicted results in acceptance order.
    t_out_item pending_results[$];

    // Predicted architectural state.
    logic [31:0] addr_regs [REG_COUNT];
    logic [31:0] data_regs [REG_COUNT];
    logic [31:0] pc_reg;
    logic [31:0] core_regs [CORE_REGS];
    logic [31:0] frame_store [FRAME_WORDS * STACK_DEPTH];
    int unsigned frames_held;

    register_file_with_context_stack_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Counts a failure and reports only the first few.
    function automatic void report_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT) begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
    endfunction

    // Applies one operation to the predicted state and returns its result.
    function automatic t_out_item execute_operation(input t_in_item it);
        t_out_item   res;
        int          slot;
        int unsigned base;
        logic [15:0] idx;
        res.read_value = '0;
        res.status     = ST_OK;
        idx            = it.register_id;
        case (it.operation)
            OP_READ_GPR, OP_WRITE_GPR: begin
                if (idx > 16'(GPR_PC_IDX)) begin
                    res.status = ST_UNKNOWN;
                end else if (idx < REG_COUNT) begin
                    if (it.operation == OP_READ_GPR) res.read_value = addr_regs[idx[3:0]];
                    else addr_regs[idx[3:0]] = it.write_value;
                end else if (idx < 2 * REG_COUNT) begin
                    if (it.operation == OP_READ_GPR) res.read_value = data_regs[idx[3:0]];
                    else data_regs[idx[3:0]] = it.write_value;
                end else begin
                    if (it.operation == OP_READ_GPR) res.read_value = pc_reg;
                    else pc_reg = it.write_value;
                end
            end
            OP_READ_CORE, OP_WRITE_CORE: begin
                slot = -1;
                for (int i = 0; i < CORE_REGS; i++) begin
                    if (CORE_ADDR[i] == idx) slot = i;
                end
                if (slot < 0) begin
                    res.status = ST_UNKNOWN;
                end else if (it.operation == OP_READ_CORE) begin
                    res.read_value = core_regs[slot];
                end else begin
                    core_regs[slot] = it.write_value;
                end
            end
            OP_SAVE: begin
                if (frames_held >= STACK_DEPTH) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    base = frames_held * FRAME_WORDS;
                    for (int i = 0; i < UPPER_A_COUNT; i++) begin
                        frame_store[base + i] = addr_regs[UPPER_A_FIRST + i];
                    end
                    for (int i = 0; i < UPPER_D_COUNT; i++) begin
                        frame_store[base + UPPER_A_COUNT + i] = data_regs[UPPER_D_FIRST + i];
                    end
                    // The return address wraps modulo 2^32.
                    frame_store[base + FRAME_WORDS - 1] = pc_reg + 32'(it.instr_bytes);
                    frames_held++;
                end
            end
            OP_RESTORE: begin
                if (frames_held == 0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    frames_held--;
                    base = frames_held * FRAME_WORDS;
                    for (int i = 0; i < UPPER_A_COUNT; i++) begin
                        addr_regs[UPPER_A_FIRST + i] = frame_store[base + i];
                    end
                    for (int i = 0; i < UPPER_D_COUNT; i++) begin
                        data_regs[UPPER_D_FIRST + i] = frame_store[base + UPPER_A_COUNT + i];
                    end
                    pc_reg = frame_store[base + FRAME_WORDS - 1];
                end
            end
            default: begin
                res.status = ST_UNKNOWN;
            end
        endcase
        return res;
    endfunction

    function automatic t_in_item make_item(input logic [2:0] op, input logic [15:0] id,
                                           input logic [31:0] value, input logic [3:0] size);
        t_in_item it;
        it.operation   = op;
        it.register_id = id;
        it.write_value = value;
        it.instr_bytes = size;
        return it;
    endfunction

    // General index of a random register that a save or restore moves.
    function automatic logic [15:0] upper_context_id();
        int unsigned k;
        k = $urandom_range(0, FRAME_WORDS - 1);
        if (k < UPPER_A_COUNT) return 16'(UPPER_A_FIRST + k);
        if (k < UPPER_A_COUNT + UPPER_D_COUNT) begin
            return 16'(REG_COUNT + UPPER_D_FIRST + k - UPPER_A_COUNT);
        end
        return 16'(GPR_PC_IDX);
    endfunction

    // Random operation, mostly with register names the block knows.
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      it.operation = OP_READ_GPR;
        else if (pick < 55) it.operation = OP_WRITE_GPR;
        else if (pick < 65) it.operation = OP_READ_CORE;
        else if (pick < 75) it.operation = OP_WRITE_CORE;
        else if (pick < 86) it.operation = OP_SAVE;
        else if (pick < 97) it.operation = OP_RESTORE;
        else it.operation = pick[0] ? OP_SPARE_LO : OP_SPARE_HI;
        case (it.operation)
            OP_READ_GPR, OP_WRITE_GPR: begin
                it.register_id = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                              : 16'($urandom_range(0, GPR_PC_IDX));
            end
            OP_READ_CORE, OP_WRITE_CORE: begin
                it.register_id = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                 : CORE_ADDR[$urandom_range(0, CORE_REGS - 1)];
            end
            default: it.register_id = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       it.write_value = '0;
            1:       it.write_value = '1;
            default: it.write_value = $urandom;
        endcase
        it.instr_bytes = 4'($urandom);
        return it;
    endfunction

    // Offers one input transaction and records its predicted result on acceptance.
    // Entered and left at a falling edge.
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(execute_operation(it));
        items_sent++;
        @(negedge clk);
    endtask

    // Takes result transactions with random stalls and checks each one.
    initial begin : result_checker
        t_out_item   want;
        int unsigned stall;
        @(negedge clk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, GAP_MAX);
            if (stall != 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (pending_results.size() == 0) begin
                report_failure($sformatf("unexpected result: value %h status %0d",
                                         out_item.read_value, out_item.status));
            end else begin
                want = pending_results.pop_front();
                if (out_item.read_value !== want.read_value || out_item.status !== want.status) begin
                    report_failure($sformatf("expected value %h status %0d, got value %h status %0d",
                                             want.read_value, want.status,
                                             out_item.read_value, out_item.status));
                end
            end
            @(negedge clk);
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    initial begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // The first address register, the pc and the last core register read as zero straight after reset.
    task automatic test_reset_state();
        send_item(make_item(OP_READ_GPR, 16'd0, '0, '0));
        send_item(make_item(OP_READ_GPR, 16'(GPR_PC_IDX), '0, '0));
        send_item(make_item(OP_READ_CORE, CORE_ADDR[CORE_REGS - 1], '0, '0));
    endtask

    // Extreme values through the first and last general registers and the pc.
    task automatic test_gpr_access();
        send_item(make_item(OP_WRITE_GPR, 16'd0, 32'hffff_ffff, '0));
        send_item(make_item(OP_WRITE_GPR, 16'(2 * REG_COUNT - 1), 32'h0000_0000, 4'hf));
        send_item(make_item(OP_WRITE_GPR, 16'(GPR_PC_IDX), 32'hffff_fff8, '0));
        send_item(make_item(OP_READ_GPR, 16'd0, '1, '0));
        send_item(make_item(OP_READ_GPR, 16'(GPR_PC_IDX), '0, '0));
    endtask

    // Core special registers written and read by address.
    task automatic test_core_access();
        send_item(make_item(OP_WRITE_CORE, CORE_ADDR[0], 32'hffff_ffff, '0));
        send_item(make_item(OP_READ_CORE, CORE_ADDR[0], '0, '0));
        send_item(make_item(OP_WRITE_CORE, CORE_ADDR[2], 32'ha5a5_5a5a, '0));
        send_item(make_item(OP_READ_CORE, CORE_ADDR[1], '0, '0));
    endtask

    // Unknown names and unused operation codes are refused and change nothing.
    task automatic test_unknown_names();
        send_item(make_item(OP_READ_GPR, 16'(GPR_PC_IDX) + 16'd1, '0, '0));
        send_item(make_item(OP_WRITE_GPR, 16'hffff, 32'hdead_beef, '0));
        send_item(make_item(OP_READ_CORE, 16'h0000, '0, '0));
        send_item(make_item(OP_WRITE_CORE, 16'hfe04, 32'h1234_5678, '0));
        send_item(make_item(OP_SPARE_LO, 16'(UPPER_A_FIRST), '1, 4'hf));
        send_item(make_item(OP_SPARE_HI, 16'd0, '1, 4'hf));
    endtask

    // Restore on an empty stack, then one save and restore with a wrapping pc.
    task automatic test_context_round_trip();
        send_item(make_item(OP_RESTORE, '0, '0, '0));
        send_item(make_item(OP_WRITE_GPR, 16'(UPPER_A_FIRST), 32'h0bad_cafe, '0));
        send_item(make_item(OP_SAVE, '0, '0, 4'hf));
        send_item(make_item(OP_WRITE_GPR, 16'(UPPER_A_FIRST), 32'h0, '0));
        send_item(make_item(OP_RESTORE, '0, '0, '0));
        send_item(make_item(OP_READ_GPR, 16'(UPPER_A_FIRST), '0, '0));
        send_item(make_item(OP_READ_GPR, 16'(GPR_PC_IDX), '0, '0));
    endtask

    // Random mix of all operations, with occasional stretches of full rate.
    task automatic test_random_traffic(input int unsigned count);
        for (int unsigned n = 0; n < count; n++) begin
            if (n % 50 == 0) steady_flow = ($urandom_range(0, 3) == 0);
            send_item(random_item());
        end
        steady_flow = 1'b0;
    endtask

    // Nested call-like sequences: set up context, save several frames, then
    // unwind them, sometimes past a full or an empty stack.
    task automatic test_nested_contexts(input int unsigned count);
        int unsigned target;
        int unsigned depth;
        target = items_sent + count;
        while (items_sent < target) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            depth = ($urandom_range(0, 2) == 0) ? STACK_DEPTH + $urandom_range(0, 2)
                                                : $urandom_range(1, STACK_DEPTH - 1);
            for (int unsigned d = 0; d < depth; d++) begin
                repeat ($urandom_range(0, 3)) begin
                    send_item(make_item(OP_WRITE_GPR, upper_context_id(), $urandom, '0));
                end
                if ($urandom_range(0, 9) == 0) send_item(random_item());
                send_item(make_item(OP_SAVE, 16'($urandom), $urandom, 4'($urandom)));
            end
            for (int unsigned d = 0; d < depth + $urandom_range(0, 1); d++) begin
                send_item(make_item(OP_RESTORE, 16'($urandom), $urandom, 4'($urandom)));
                repeat ($urandom_range(0, 2)) begin
                    send_item(make_item(OP_READ_GPR, upper_context_id(), $urandom, '0));
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    // Reset, the directed checks, the random phases, then drain and report.
    initial begin : main_sequence
        for (int i = 0; i < REG_COUNT; i++) begin
            addr_regs[i] = '0;
            data_regs[i] = '0;
        end
        for (int i = 0; i < CORE_REGS; i++) core_regs[i] = '0;
        for (int i = 0; i < FRAME_WORDS * STACK_DEPTH; i++) frame_store[i] = '0;
        pc_reg      = '0;
        frames_held = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_gpr_access();
        test_core_access();
        test_unknown_names();
        test_context_round_trip();
        test_random_traffic(RANDOM_ITEMS);
        test_nested_contexts(NESTED_ITEMS);
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
